>>> sv/inms_pkg.sv
package inms_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int MAG_BITS   = 16;
    localparam int ANG_BITS   = 12;
    localparam int FRAC_BITS  = 10;
    localparam int DIM_BITS   = 13;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int CNT_BITS   = 24;
    localparam int TOTAL_BITS = CNT_BITS + 1;
    localparam int PROD_BITS  = MAG_BITS + FRAC_BITS + 1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam logic [TOTAL_BITS-1:0] RESET_TOTAL = TOTAL_BITS'(RESET_WIDTH * RESET_HEIGHT);

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [1:0] SECTOR_0 = 2'd0;
    localparam logic [1:0] SECTOR_1 = 2'd1;
    localparam logic [1:0] SECTOR_2 = 2'd2;
    localparam logic [1:0] SECTOR_3 = 2'd3;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_BITS  = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_BITS  = $clog2(OUTQ_DEPTH);

    localparam int DIV_STEPS    = CNT_BITS;
    localparam int DIV_LOAD     = DIV_STEPS + 1;
    localparam int DIV_START    = DIV_STEPS + 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_START + 1);

    typedef struct packed {
        logic [COL_BITS-1:0] x;
        logic [MAG_BITS-1:0] mag;
        logic [ANG_BITS-1:0] ang;
        logic                emit;
        logic                interior;
        logic                eof;
    } t_cmd;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic                eof;
    } t_result;

endpackage

>>> sv/inms_front.sv
module inms_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [inms_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [inms_pkg::DIM_BITS-1:0]       i_cfg_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_is_flush,
    input  logic [inms_pkg::MAG_BITS-1:0]       i_magnitude,
    input  logic [inms_pkg::ANG_BITS-1:0]       i_angle_code,
    input  logic                                i_back_busy,
    input  logic                                i_cmd_pop,
    output logic                                o_cmd_valid,
    output inms_pkg::t_cmd                      o_cmd
);

    localparam int DB = inms_pkg::DIM_BITS;
    localparam int CB = inms_pkg::COL_BITS;
    localparam int RB = inms_pkg::ROW_BITS;
    localparam int NB = inms_pkg::CNT_BITS;
    localparam int TB = inms_pkg::TOTAL_BITS;

    logic [DB-1:0] r_frame_width, r_frame_height;
    logic [DB-1:0] r_w_eff, r_h_eff;
    logic [DB-1:0] w_clamp, h_clamp;
    logic [2*DB-1:0] prod_total;
    logic [TB-1:0] r_total;

    logic [inms_pkg::DIV_CNT_BITS-1:0] r_div_cnt;
    logic [CB-1:0] r_rem;
    logic [NB-1:0] r_quo;
    logic [DB-1:0] div_sh;
    logic [DB:0]   div_diff;
    logic          div_ge;
    logic [CB-1:0] div_rem;
    logic [NB-1:0] div_quo;

    logic [CB-1:0] r_in_col, n_in_col;
    logic [RB-1:0] r_in_row, n_in_row;
    logic [NB-1:0] r_out_cnt, n_out_cnt;
    logic [NB-1:0] r_out_row, n_out_row;
    logic [CB-1:0] r_out_col, n_out_col;
    logic          r_drain, n_drain;

    inms_pkg::t_cmd r_q [inms_pkg::CMDQ_DEPTH];
    logic [inms_pkg::CMDQ_BITS-1:0] r_wp, r_rp;
    logic [inms_pkg::CMDQ_BITS:0]   r_qcnt;

    logic          acc, step_pixel, emit, produce, wrap_col, wrap_row, drain_after;
    logic          interior, eof, enq;
    logic [DB-1:0] col_inc, row_inc, ocol_inc;
    logic [CB-1:0] vx;
    inms_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_clamp = r_frame_width;
        if (r_frame_width < DB'(inms_pkg::MIN_DIM)) begin
            w_clamp = DB'(inms_pkg::MIN_DIM);
        end else if (r_frame_width > DB'(inms_pkg::MAX_WIDTH)) begin
            w_clamp = DB'(inms_pkg::MAX_WIDTH);
        end
        h_clamp = r_frame_height;
        if (r_frame_height < DB'(inms_pkg::MIN_DIM)) begin
            h_clamp = DB'(inms_pkg::MIN_DIM);
        end else if (r_frame_height > DB'(inms_pkg::MAX_HEIGHT)) begin
            h_clamp = DB'(inms_pkg::MAX_HEIGHT);
        end
    end

    assign prod_total = {{DB{1'b0}}, r_w_eff} * {{DB{1'b0}}, r_h_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DB'(inms_pkg::RESET_WIDTH);
            r_frame_height <= DB'(inms_pkg::RESET_HEIGHT);
            r_w_eff        <= DB'(inms_pkg::RESET_WIDTH);
            r_h_eff        <= DB'(inms_pkg::RESET_HEIGHT);
            r_total        <= inms_pkg::RESET_TOTAL;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    inms_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    inms_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_w_eff <= w_clamp;
            r_h_eff <= h_clamp;
            r_total <= prod_total[TB-1:0];
        end
    end

    // restoring divider: output position = out_count / width, one bit a cycle
    assign div_sh   = {r_rem, r_quo[NB-1]};
    assign div_diff = {1'b0, div_sh} - {1'b0, r_w_eff};
    assign div_ge   = !div_diff[DB];
    assign div_rem  = div_ge ? div_diff[CB-1:0] : div_sh[CB-1:0];
    assign div_quo  = {r_quo[NB-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cfg_valid) begin
            r_div_cnt <= inms_pkg::DIV_CNT_BITS'(inms_pkg::DIV_START);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_cnt == inms_pkg::DIV_CNT_BITS'(inms_pkg::DIV_LOAD)) begin
            r_rem <= '0;
            r_quo <= r_out_cnt;
        end else begin
            r_rem <= div_rem;
            r_quo <= div_quo;
        end
    end

    assign acc        = i_push && !o_full;
    assign step_pixel = !r_drain && !i_is_flush;
    assign col_inc    = {1'b0, r_in_col} + 1'b1;
    assign row_inc    = {1'b0, r_in_row} + 1'b1;
    assign wrap_col   = col_inc >= r_w_eff;
    assign wrap_row   = wrap_col && (row_inc >= r_h_eff);
    assign produce    = (r_in_row >= RB'(2)) || ((r_in_row == RB'(1)) && (r_in_col != '0));
    assign ocol_inc   = {1'b0, r_out_col} + 1'b1;
    assign vx         = (ocol_inc == r_w_eff) ? '0 : ocol_inc[CB-1:0];
    assign emit       = r_drain || (step_pixel && produce);
    assign drain_after = r_drain || (step_pixel && wrap_row);
    assign interior   = (r_out_row != '0) && (r_out_row < (NB'(r_h_eff) - 1'b1))
                     && (r_out_col != '0) && ({1'b0, r_out_col} != (r_w_eff - 1'b1));
    assign eof        = ({1'b0, r_out_cnt} + 1'b1) >= r_total;
    assign enq        = acc && (r_drain || !i_is_flush);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_cnt = r_out_cnt;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_drain   = r_drain;
        if (acc) begin
            if (step_pixel) begin
                n_in_col = wrap_col ? '0 : col_inc[CB-1:0];
                if (wrap_col) begin
                    n_in_row = wrap_row ? '0 : row_inc[RB-1:0];
                end
                n_drain = wrap_row;
            end
            if (emit) begin
                if (eof) begin
                    n_out_cnt = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                    if (drain_after) begin
                        n_drain  = 1'b0;
                        n_in_row = '0;
                        n_in_col = '0;
                    end
                end else begin
                    n_out_cnt = r_out_cnt + 1'b1;
                    if (ocol_inc == r_w_eff) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = ocol_inc[CB-1:0];
                    end
                end
            end
        end else if (r_div_cnt == inms_pkg::DIV_CNT_BITS'(1)) begin
            n_out_row = div_quo;
            n_out_col = div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_cnt <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_drain   <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_cnt <= n_out_cnt;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_drain   <= n_drain;
        end
    end

    always_comb begin
        cmd.x        = r_drain ? vx : r_in_col;
        cmd.mag      = r_drain ? '0 : i_magnitude;
        cmd.ang      = r_drain ? '0 : i_angle_code;
        cmd.emit     = emit;
        cmd.interior = interior;
        cmd.eof      = eof;
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_qcnt <= r_qcnt + (inms_pkg::CMDQ_BITS+1)'(enq)
                             - (inms_pkg::CMDQ_BITS+1)'(i_cmd_pop);
        end
    end

    assign o_cmd_valid = r_qcnt != '0;
    assign o_cmd       = r_q[r_rp];
    assign o_full      = (r_qcnt == (inms_pkg::CMDQ_BITS+1)'(inms_pkg::CMDQ_DEPTH))
                      || (r_div_cnt != '0) || i_back_busy;

endmodule

>>> sv/inms_back.sv
module inms_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  inms_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_busy,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [inms_pkg::MAG_BITS-1:0]  o_out_magnitude,
    output logic                           o_end_of_frame
);

    localparam int MB = inms_pkg::MAG_BITS;
    localparam int AB = inms_pkg::ANG_BITS;
    localparam int CB = inms_pkg::COL_BITS;
    localparam int FB = inms_pkg::FRAC_BITS;
    localparam int PB = inms_pkg::PROD_BITS;
    localparam int OB = inms_pkg::OUTQ_BITS;

    logic [MB-1:0] r_upper_mem  [inms_pkg::MAX_WIDTH];
    logic [MB-1:0] r_middle_mem [inms_pkg::MAX_WIDTH];
    logic [AB-1:0] r_angle_mem  [inms_pkg::MAX_WIDTH];

    logic          r_clearing;
    logic [CB-1:0] r_clr_addr;

    logic           r_s1_v;
    inms_pkg::t_cmd r_s1;
    logic [MB-1:0]  r_up_rd, r_mid_rd;
    logic [AB-1:0]  r_ang_rd;
    logic           r_byp_v;
    logic [MB-1:0]  r_byp_up, r_byp_mid;
    logic [AB-1:0]  r_byp_ang;
    logic [MB-1:0]  up_e, mid_e;
    logic [AB-1:0]  ang_e;

    logic          mem_we;
    logic [CB-1:0] mem_wa;
    logic [MB-1:0] wd_up, wd_mid;
    logic [AB-1:0] wd_ang;

    logic [MB-1:0] r_win [9];
    logic [MB-1:0] n_win [9];
    logic [AB-1:0] r_newest_ang;

    logic          r_s2_v, r_s2_interior, r_s2_eof;
    logic [AB-1:0] r_s2_ang;
    logic [1:0]    sector;
    logic [FB-1:0] frac;
    logic [FB:0]   frac_c;
    logic [MB-1:0] a1, b1, a2, b2;

    logic          r_s3_v, r_s3_interior, r_s3_eof;
    logic [MB-1:0] r_s3_c;
    logic [PB-1:0] r_s3_pa1, r_s3_pb1, r_s3_pa2, r_s3_pb2;
    logic [PB-1:0] v1, v2, cw;
    logic          suppress;
    inms_pkg::t_result res;

    inms_pkg::t_result r_oq [inms_pkg::OUTQ_DEPTH];
    logic [OB-1:0] r_owp, r_orp;
    logic [OB:0]   r_oq_cnt;
    logic [1:0]    pend;
    logic          oq_pop;

    // line stores are cleared once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CB'(inms_pkg::MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign pend = 2'(r_s1_v && r_s1.emit) + 2'(r_s2_v) + 2'(r_s3_v);
    assign o_cmd_pop = i_cmd_valid && !r_clearing
                    && (({1'b0, r_oq_cnt} + (OB+2)'(pend)) < (OB+2)'(inms_pkg::OUTQ_DEPTH));
    assign o_busy = r_clearing;

    // same-address write in flight is forwarded
    assign up_e  = r_byp_v ? r_byp_up  : r_up_rd;
    assign mid_e = r_byp_v ? r_byp_mid : r_mid_rd;
    assign ang_e = r_byp_v ? r_byp_ang : r_ang_rd;

    assign mem_we = r_clearing || r_s1_v;
    assign mem_wa = r_clearing ? r_clr_addr : r_s1.x;
    assign wd_up  = r_clearing ? '0 : mid_e;
    assign wd_mid = r_clearing ? '0 : r_s1.mag;
    assign wd_ang = r_clearing ? '0 : r_s1.ang;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_upper_mem[mem_wa] <= wd_up;
        end
        if (o_cmd_pop) begin
            r_up_rd <= r_upper_mem[i_cmd.x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_middle_mem[mem_wa] <= wd_mid;
        end
        if (o_cmd_pop) begin
            r_mid_rd <= r_middle_mem[i_cmd.x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_angle_mem[mem_wa] <= wd_ang;
        end
        if (o_cmd_pop) begin
            r_ang_rd <= r_angle_mem[i_cmd.x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_byp_v <= 1'b0;
        end else begin
            r_s1_v  <= o_cmd_pop;
            r_byp_v <= o_cmd_pop && r_s1_v && (r_s1.x == i_cmd.x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1      <= i_cmd;
            r_byp_up  <= mid_e;
            r_byp_mid <= r_s1.mag;
            r_byp_ang <= r_s1.ang;
        end
    end

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = up_e;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = mid_e;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1.mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
            r_newest_ang <= '0;
            r_s2_v       <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v && r_s1.emit;
            if (r_s1_v) begin
                for (int i = 0; i < 9; i++) begin
                    r_win[i] <= n_win[i];
                end
                r_newest_ang <= ang_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_ang      <= r_newest_ang;
            r_s2_interior <= r_s1.interior;
            r_s2_eof      <= r_s1.eof;
        end
    end

    assign sector = r_s2_ang[FB+1:FB];
    assign frac   = r_s2_ang[FB-1:0];
    assign frac_c = (FB+1)'(1 << FB) - {1'b0, frac};

    always_comb begin
        a1 = r_win[8];
        b1 = r_win[5];
        a2 = r_win[0];
        b2 = r_win[3];
        unique case (sector)
            inms_pkg::SECTOR_3: begin
                a1 = r_win[3]; b1 = r_win[6]; a2 = r_win[5]; b2 = r_win[2];
            end
            inms_pkg::SECTOR_2: begin
                a1 = r_win[6]; b1 = r_win[7]; a2 = r_win[2]; b2 = r_win[1];
            end
            inms_pkg::SECTOR_1: begin
                a1 = r_win[7]; b1 = r_win[8]; a2 = r_win[1]; b2 = r_win[0];
            end
            inms_pkg::SECTOR_0: begin
                a1 = r_win[8]; b1 = r_win[5]; a2 = r_win[0]; b2 = r_win[3];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_s3_pa1      <= PB'({{(FB+1){1'b0}}, a1} * {{(MB+1){1'b0}}, frac});
            r_s3_pb1      <= PB'({{FB{1'b0}}, b1} * {{MB{1'b0}}, frac_c});
            r_s3_pa2      <= PB'({{(FB+1){1'b0}}, a2} * {{(MB+1){1'b0}}, frac});
            r_s3_pb2      <= PB'({{FB{1'b0}}, b2} * {{MB{1'b0}}, frac_c});
            r_s3_c        <= r_win[4];
            r_s3_interior <= r_s2_interior;
            r_s3_eof      <= r_s2_eof;
        end
    end

    assign v1       = r_s3_pa1 + r_s3_pb1;
    assign v2       = r_s3_pa2 + r_s3_pb2;
    assign cw       = {1'b0, r_s3_c, {FB{1'b0}}};
    assign suppress = r_s3_interior && ((cw < v1) || (cw <= v2));
    assign res.mag  = suppress ? '0 : r_s3_c;
    assign res.eof  = r_s3_eof;

    assign oq_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s3_v) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp    <= '0;
            r_orp    <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s3_v) begin
                r_owp <= r_owp + 1'b1;
            end
            if (oq_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + (OB+1)'(r_s3_v) - (OB+1)'(oq_pop);
        end
    end

    assign o_empty         = r_oq_cnt == '0;
    assign o_out_magnitude = r_oq[r_orp].mag;
    assign o_end_of_frame  = r_oq[r_orp].eof;

endmodule

>>> sv/interpolated_nonmax_suppression.sv
// A taken item passes the command queue, the line-store read, window and product stages
// and the output queue before its result is on the output ports. Throughput: one item
// per clock while full is low; the line stores take one read and one write per cycle.
// Reset: a pass zeroes the line stores, full stays high meanwhile. A register write holds
// full high while the output position is re-derived by a one-bit-per-cycle divider.
module interpolated_nonmax_suppression (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [inms_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [inms_pkg::DIM_BITS-1:0]       i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_is_flush,
    input  logic [inms_pkg::MAG_BITS-1:0]       i_magnitude,
    input  logic [inms_pkg::ANG_BITS-1:0]       i_angle_code,
    output logic                                empty,
    input  logic                                pop,
    output logic [inms_pkg::MAG_BITS-1:0]       o_out_magnitude,
    output logic                                o_end_of_frame
);

    inms_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;
    logic           back_busy;

    inms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_is_flush   (i_is_flush),
        .i_magnitude  (i_magnitude),
        .i_angle_code (i_angle_code),
        .i_back_busy  (back_busy),
        .i_cmd_pop    (cmd_pop),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    inms_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_busy          (back_busy),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_magnitude (o_out_magnitude),
        .o_end_of_frame  (o_end_of_frame)
    );

endmodule

>>> tb/interpolated_nonmax_suppression_tb.sv
`timescale 1ns / 1ps

module interpolated_nonmax_suppression_tb;

    localparam int MAG_BITS      = inms_pkg::MAG_BITS;
    localparam int ANG_BITS      = inms_pkg::ANG_BITS;
    localparam int FRAC_BITS     = inms_pkg::FRAC_BITS;
    localparam int DIM_BITS      = inms_pkg::DIM_BITS;
    localparam int CFG_IDX_BITS  = inms_pkg::CFG_IDX_BITS;
    localparam int MAX_WIDTH     = inms_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT    = inms_pkg::MAX_HEIGHT;
    localparam int MIN_DIM       = inms_pkg::MIN_DIM;
    localparam int RESET_WIDTH   = inms_pkg::RESET_WIDTH;
    localparam int RESET_HEIGHT  = inms_pkg::RESET_HEIGHT;
    localparam int SETTLE_CYCLES = 16;
    localparam int FRAC_ONE      = 1 << FRAC_BITS;

    typedef struct {
        bit                  flush;
        logic [MAG_BITS-1:0] mag;
        logic [ANG_BITS-1:0] ang;
    } t_grad_px;

    logic                    i_clk;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_valid  = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index  = '0;
    logic [DIM_BITS-1:0]     i_cfg_data   = '0;
    logic                    push         = 1'b0;
    logic                    full;
    logic                    i_is_flush   = 1'b0;
    logic [MAG_BITS-1:0]     i_magnitude  = '0;
    logic [ANG_BITS-1:0]     i_angle_code = '0;
    logic                    empty;
    logic                    pop          = 1'b0;
    logic [MAG_BITS-1:0]     o_out_magnitude;
    logic                    o_end_of_frame;

    interpolated_nonmax_suppression dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_is_flush      (i_is_flush),
        .i_magnitude     (i_magnitude),
        .i_angle_code    (i_angle_code),
        .empty           (empty),
        .pop             (pop),
        .o_out_magnitude (o_out_magnitude),
        .o_end_of_frame  (o_end_of_frame)
    );

    // predictor state
    logic [DIM_BITS-1:0] cfg_width  = DIM_BITS'(RESET_WIDTH);
    logic [DIM_BITS-1:0] cfg_height = DIM_BITS'(RESET_HEIGHT);
    logic [MAG_BITS-1:0] upper_line  [MAX_WIDTH];
    logic [MAG_BITS-1:0] middle_line [MAX_WIDTH];
    logic [ANG_BITS-1:0] angle_line  [MAX_WIDTH];
    logic [MAG_BITS-1:0] window [9];
    logic [ANG_BITS-1:0] newest_ang;
    int unsigned         line_col, line_row, out_pos;
    bit                  draining;

    inms_pkg::t_result expected_px [$];
    t_grad_px    pixel_feed [$];
    bit          sent_now, tx_hold, rx_hold, rx_hold_req;
    int unsigned tx_idle_pct, rx_idle_pct;
    int unsigned error_count;

    function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned blend_pair(int ia, int ib, longint unsigned f);
        return longint'(window[ia]) * f + longint'(window[ib]) * (FRAC_ONE - f);
    endfunction

    // shift one column into the window; returns the angle of the new centre
    function automatic logic [ANG_BITS-1:0] shift_window(int unsigned x,
                                                        logic [MAG_BITS-1:0] mag,
                                                        logic [ANG_BITS-1:0] ang);
        logic [MAG_BITS-1:0] up, mid;
        logic [ANG_BITS-1:0] a, centre_ang;
        up  = '0;
        mid = '0;
        a   = '0;
        if (x < MAX_WIDTH) begin
            up             = upper_line[x];
            mid            = middle_line[x];
            a              = angle_line[x];
            upper_line[x]  = mid;
            middle_line[x] = mag;
            angle_line[x]  = ang;
        end
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2]  = up;
        window[5]  = mid;
        window[8]  = mag;
        centre_ang = newest_ang;
        newest_ang = a;
        return centre_ang;
    endfunction

    function automatic void judge_centre(logic [ANG_BITS-1:0] ang);
        int unsigned       w, h, orow, ocol;
        longint unsigned   f, c, v1, v2;
        inms_pkg::t_result res;
        w        = clamp_dim(cfg_width, MAX_WIDTH);
        h        = clamp_dim(cfg_height, MAX_HEIGHT);
        orow     = out_pos / w;
        ocol     = out_pos % w;
        res.mag  = window[4];
        if (orow != 0 && orow < h - 1 && ocol != 0 && ocol != w - 1) begin
            f = ang[FRAC_BITS-1:0];
            c = longint'(window[4]) * FRAC_ONE;
            case (ang[FRAC_BITS +: 2])
                inms_pkg::SECTOR_3: begin
                    v1 = blend_pair(3, 6, f);
                    v2 = blend_pair(5, 2, f);
                end
                inms_pkg::SECTOR_2: begin
                    v1 = blend_pair(6, 7, f);
                    v2 = blend_pair(2, 1, f);
                end
                inms_pkg::SECTOR_1: begin
                    v1 = blend_pair(7, 8, f);
                    v2 = blend_pair(1, 0, f);
                end
                default: begin
                    v1 = blend_pair(8, 5, f);
                    v2 = blend_pair(0, 3, f);
                end
            endcase
            if (c < v1 || c <= v2) res.mag = '0;
        end
        res.eof = (out_pos + 1 >= w * h);
        if (res.eof) begin
            out_pos = 0;
            if (draining) begin
                draining = 1'b0;
                line_row = 0;
                line_col = 0;
            end
        end else begin
            out_pos = (out_pos + 1) & 32'hFF_FFFF;
        end
        expected_px.push_back(res);
    endfunction

    function automatic void advance_pixel(bit flush, logic [MAG_BITS-1:0] mag,
                                          logic [ANG_BITS-1:0] ang);
        int unsigned         w, h;
        bit                  produce;
        logic [ANG_BITS-1:0] centre_ang;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        if (draining) begin
            // pixel or flush alike: feed a zero pixel, emit one pending result
            centre_ang = shift_window((out_pos + 1) % w, '0, '0);
            judge_centre(centre_ang);
            return;
        end
        if (flush) return;
        produce    = line_row >= 2 || (line_row == 1 && line_col >= 1);
        centre_ang = shift_window(line_col, mag, ang);
        line_col++;
        if (line_col >= w) begin
            line_col = 0;
            line_row++;
            if (line_row >= h) begin
                line_row = 0;
                draining = 1'b1;
            end
        end
        if (produce) judge_centre(centre_ang);
    endfunction

    function automatic t_grad_px make_pixel(bit flush);
        t_grad_px p;
        p.flush = flush;
        case ($urandom_range(2))
            0:       p.mag = MAG_BITS'($urandom);
            1:       p.mag = MAG_BITS'($urandom_range(3));
            default: p.mag = MAG_BITS'(1000 + $urandom_range(40));
        endcase
        p.ang = ANG_BITS'($urandom);
        if ($urandom_range(7) == 0)
            p.ang[FRAC_BITS-1:0] = $urandom_range(1) ? '1 : '0;
        return p;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DIM_BITS'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == inms_pkg::REG_FRAME_WIDTH) cfg_width = DIM_BITS'(val);
        else if (idx == inms_pkg::REG_FRAME_HEIGHT) cfg_height = DIM_BITS'(val);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_feed.size() != 0 || push || expected_px.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // whole frames from a clean start, noise flushes inside, mixed drain items
    task automatic queue_frames(input int unsigned count);
        int unsigned w, h;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        repeat (count) begin
            repeat (w * h) begin
                if ($urandom_range(99) < 6) pixel_feed.push_back(make_pixel(1'b1));
                pixel_feed.push_back(make_pixel(1'b0));
            end
            repeat (w + 1) pixel_feed.push_back(make_pixel(1'($urandom_range(1))));
        end
    endtask

    // bring the block back to the start of a frame with nothing pending
    task automatic close_frame();
        int unsigned w, h, px;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        while (!draining && (line_col != 0 || line_row != 0)) begin
            // a column past a narrowed row wraps on the next pixel
            if (line_col >= w) px = 1;
            else px = ((line_row >= h) ? 1 : h - line_row) * w - line_col;
            repeat (px) pixel_feed.push_back(make_pixel(1'b0));
            wait_idle();
        end
        while (draining) begin
            repeat (w + 1) pixel_feed.push_back(make_pixel(1'b1));
            wait_idle();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge i_clk) begin : driver
        t_grad_px nxt;
        if (!push || sent_now) begin
            sent_now = 1'b0;
            if (i_rst_n && !tx_hold && pixel_feed.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                nxt = pixel_feed.pop_front();
                push         <= 1'b1;
                i_is_flush   <= nxt.flush;
                i_magnitude  <= nxt.mag;
                i_angle_code <= nxt.ang;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off so the block fills and pushes back
    initial begin
        wait (rx_hold_req);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        inms_pkg::t_result want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_px.size() == 0) begin
                    error_count++;
                    $error("unexpected result: out_magnitude %0d end_of_frame %0b",
                           o_out_magnitude, o_end_of_frame);
                end else begin
                    want = expected_px.pop_front();
                    if (o_out_magnitude !== want.mag) begin
                        error_count++;
                        $error("out_magnitude: expected %0d, got %0d",
                               want.mag, o_out_magnitude);
                    end
                    if (o_end_of_frame !== want.eof) begin
                        error_count++;
                        $error("end_of_frame: expected %0b, got %0b",
                               want.eof, o_end_of_frame);
                    end
                end
            end
            if (push && !full) begin
                advance_pixel(i_is_flush, i_magnitude, i_angle_code);
                sent_now = 1'b1;
            end
        end
    end

    initial begin
        logic [MAG_BITS-1:0] mid_mags [6];
        logic [ANG_BITS-1:0] mid_angs [6];
        int unsigned w, h;

        mid_mags = '{16'h0000, 16'hFFFF, 16'd500, 16'd500, 16'hFFFF, 16'h0000};
        mid_angs = '{12'hFFF, 12'h000, 12'h7FF, 12'h800, 12'hC01, 12'h3FF};
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
            angle_line[i]  = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        newest_ang  = '0;
        tx_idle_pct = 25;
        rx_idle_pct = 66;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frame, 6 x 3: one interior pixel per sector, extreme values
        write_reg(inms_pkg::REG_FRAME_WIDTH, 6);
        write_reg(inms_pkg::REG_FRAME_HEIGHT, 3);
        pixel_feed.push_back('{1'b1, '0, '0});
        for (int i = 0; i < 6; i++)
            pixel_feed.push_back('{1'b0, 16'hFFFF, ANG_BITS'($urandom)});
        pixel_feed.push_back('{1'b1, 16'hFFFF, 12'hFFF});
        for (int i = 0; i < 6; i++)
            pixel_feed.push_back('{1'b0, mid_mags[i], mid_angs[i]});
        for (int i = 0; i < 6; i++)
            pixel_feed.push_back('{1'b0, 16'h0000, ANG_BITS'($urandom)});
        // drain, with a pixel that gets dropped
        pixel_feed.push_back('{1'b1, '0, '0});
        pixel_feed.push_back('{1'b0, 16'hFFFF, 12'hFFF});
        repeat (5) pixel_feed.push_back('{1'b1, '0, '0});
        wait_idle();
        close_frame();

        for (int ph = 0; ph < 12; ph++) begin
            tx_idle_pct = ph < 4 ? 25 : (ph < 8 ? 66 : 0);
            rx_idle_pct = ph < 4 ? 66 : (ph < 8 ? 25 : 0);
            write_reg(inms_pkg::REG_FRAME_WIDTH, ph == 0 ? 3 : $urandom_range(12, 3));
            write_reg(inms_pkg::REG_FRAME_HEIGHT, ph == 1 ? 3 : $urandom_range(8, 3));
            w = clamp_dim(cfg_width, MAX_WIDTH);
            h = clamp_dim(cfg_height, MAX_HEIGHT);
            queue_frames(75 / (w * h + w + 1) + 1);
            if (ph == 2) begin
                // sender pauses until every result so far is out
                while (pixel_feed.size() > 50) @(posedge i_clk);
                tx_hold = 1'b1;
                do @(posedge i_clk);
                while (push || expected_px.size() != 0);
                tx_hold = 1'b0;
            end
            if (ph == 5) rx_hold_req = 1'b1;
            wait_idle();
            close_frame();
        end

        // height cut mid-frame, result count already past the new frame end
        write_reg(inms_pkg::REG_FRAME_WIDTH, 8);
        write_reg(inms_pkg::REG_FRAME_HEIGHT, 6);
        repeat (4 * 8 + 3) pixel_feed.push_back(make_pixel(1'b0));
        wait_idle();
        write_reg(inms_pkg::REG_FRAME_HEIGHT, 3);
        close_frame();

        // out-of-range register values clamp to the size limits
        write_reg(inms_pkg::REG_FRAME_WIDTH, 0);
        write_reg(inms_pkg::REG_FRAME_HEIGHT, 0);
        queue_frames(1);
        wait_idle();
        close_frame();

        // widest row and tallest frame, then narrowed mid-frame
        write_reg(inms_pkg::REG_FRAME_WIDTH, 8191);
        write_reg(inms_pkg::REG_FRAME_HEIGHT, 8191);
        repeat (60) pixel_feed.push_back(make_pixel(1'b0));
        wait_idle();
        write_reg(inms_pkg::REG_FRAME_WIDTH, 5);
        write_reg(inms_pkg::REG_FRAME_HEIGHT, 3);
        close_frame();

        do @(posedge i_clk);
        while (pixel_feed.size() != 0 || push);
        for (int k = 0; k < 20000 && expected_px.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_px.size() != 0) begin
            $error("%0d expected results never arrived", expected_px.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
sv/inms_pkg.sv
sv/inms_front.sv
sv/inms_back.sv
sv/interpolated_nonmax_suppression.sv
tb/interpolated_nonmax_suppression_tb.sv
